// File: hw/rtl/lbp_pkg.sv
package lbp_pkg;

   // Width of the caller's machine word; lengths above it are saturated.
   localparam int WordBits = 32;

   // Width of the code value field.
   localparam int ValueBits = 32;

   // Largest length that is honored: the smaller of the word and value widths.
   localparam int LenCap = (WordBits < ValueBits) ? WordBits : ValueBits;

   // Depth of the queue between the front and back parts.
   localparam int QueueDepth = 2;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   // One input word.
   typedef struct packed {
      logic [31:0] code_value;
      logic [5:0]  code_length;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [7:0] packed_byte;
      logic       run_last;
   } rsp_type;

   // A run of completed bytes handed from the front part to the back part.
   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  nbytes;
   } run_type;

   // Status of the queue as seen by its neighbors.
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// File: hw/rtl/lsb_first_bit_packer.sv
// The bytes a word completes pass the run queue and then the output register to rsp_word.
// Throughput: one output byte per cycle while rsp_pop is held, set by the single output
// register of the back part; an input word completes at most four bytes.
// A two-entry run queue lets the front accept while the back drains earlier bytes.
// Reset (synchronous, active high) clears the pending bits, the queue and the output valid flag.
module lsb_first_bit_packer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  lbp_pkg::req_type req_word,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output lbp_pkg::rsp_type rsp_word
);

   logic               accept;
   logic               run_push;
   logic               run_pop;
   lbp_pkg::run_type   run_word;
   lbp_pkg::run_type   head_word;
   lbp_pkg::qstat_type stat;

   // Input is held while the run queue is full.
   assign req_full = stat.full;
   assign accept   = req_push && !stat.full;

   lbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .run_push (run_push),
      .run_word (run_word)
   );

   lbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (run_push),
      .push_word (run_word),
      .pop       (run_pop),
      .head_word (head_word),
      .stat      (stat)
   );

   lbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_word (head_word),
      .stat      (stat),
      .run_pop   (run_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

// File: hw/rtl/lbp_front.sv
module lbp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  lbp_pkg::req_type  req_word,
   output logic              run_push,
   output lbp_pkg::run_type  run_word
);

   logic [6:0]  pending_ff;
   logic [6:0]  pending_in;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic [5:0]  len_eff;
   logic [63:0] mask;
   logic [31:0] value_masked;
   logic [38:0] acc;
   logic [38:0] acc_rest;
   logic [5:0]  total;
   logic [2:0]  nbytes;

   // Saturate the length and drop value bits above it.
   always_comb begin
      if (req_word.code_length > 6'(lbp_pkg::LenCap)) begin
         len_eff = 6'(lbp_pkg::LenCap);
      end else begin
         len_eff = req_word.code_length;
      end
      mask         = (64'd1 << len_eff) - 64'd1;
      value_masked = req_word.code_value & mask[31:0];
   end

   // Place the new bits above the pending ones and split off whole bytes.
   always_comb begin
      acc        = {32'd0, pending_ff} | ({7'd0, value_masked} << count_ff);
      total      = {3'd0, count_ff} + len_eff;
      nbytes     = total[5:3];
      acc_rest   = acc >> {nbytes, 3'b000};
      pending_in = pending_ff;
      count_in   = count_ff;
      if (accept) begin
         pending_in = acc_rest[6:0];
         count_in   = total[2:0];
      end
   end

   // Only items that complete at least one byte reach the back part.
   assign run_push        = accept && (nbytes != 3'd0);
   assign run_word.bytes  = acc[31:0];
   assign run_word.nbytes = nbytes;

   // Residual bit state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 7'd0;
         count_ff   <= 3'd0;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

   // Pending bits above the pending count are always clear.
   assert property (@(posedge clock) disable iff (reset)
      (pending_ff >> count_ff) == 7'd0)
      else $error("Stray bits above the pending count.");

   // A pushed run never holds more than four bytes.
   assert property (@(posedge clock) disable iff (reset)
      run_push |-> (nbytes <= 3'd4))
      else $error("Run longer than four bytes.");

   // An item that completes no byte leaves fewer than eight bits pending.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !run_push) |=> ({3'd0, count_ff} == $past(total)))
      else $error("Pending count lost on an item without output.");

endmodule

// File: hw/rtl/lbp_queue.sv
module lbp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lbp_pkg::run_type   push_word,
   input  logic               pop,
   output lbp_pkg::run_type   head_word,
   output lbp_pkg::qstat_type stat
);

   localparam int CountBits = lbp_pkg::QueuePtrBits + 1;

   lbp_pkg::run_type                  mem [lbp_pkg::QueueDepth];
   logic [lbp_pkg::QueuePtrBits-1:0]  wr_ptr_ff;
   logic [lbp_pkg::QueuePtrBits-1:0]  wr_ptr_in;
   logic [lbp_pkg::QueuePtrBits-1:0]  rd_ptr_ff;
   logic [lbp_pkg::QueuePtrBits-1:0]  rd_ptr_in;
   logic [CountBits-1:0]              count_ff;
   logic [CountBits-1:0]              count_in;
   logic                              do_push;
   logic                              do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CountBits'(lbp_pkg::QueueDepth));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_word  = mem[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The fill count agrees with the pointer distance.
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[lbp_pkg::QueuePtrBits-1:0])
      else $error("Queue count and pointers disagree.");

   // The fill count never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(lbp_pkg::QueueDepth))
      else $error("Queue overfilled.");

   // A push into a full queue never happens.
   assert property (@(posedge clock) disable iff (reset)
      !(push && stat.full))
      else $error("Push into a full queue.");

endmodule

// File: hw/rtl/lbp_back.sv
module lbp_back (
   input  logic               clock,
   input  logic               reset,
   input  lbp_pkg::run_type   head_word,
   input  lbp_pkg::qstat_type stat,
   output logic               run_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output lbp_pkg::rsp_type   rsp_word
);

   logic             out_valid_ff;
   logic             out_valid_in;
   lbp_pkg::rsp_type out_ff;
   lbp_pkg::rsp_type out_in;
   logic [1:0]       idx_ff;
   logic [1:0]       idx_in;
   logic             load;
   logic             last;

   // Move the next byte into the output register whenever it is free.
   always_comb begin
      load         = !stat.empty && (!out_valid_ff || rsp_pop);
      last         = (({1'b0, idx_ff} + 3'd1) == head_word.nbytes);
      out_in       = out_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (load) begin
         out_in.packed_byte = head_word.bytes[{idx_ff, 3'b000} +: 8];
         out_in.run_last    = last;
         out_valid_in       = 1'b1;
         idx_in             = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   assign run_pop   = load && last;
   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // The byte index always points inside the run at the queue head.
   assert property (@(posedge clock) disable iff (reset)
      !stat.empty |-> ({1'b0, idx_ff} < head_word.nbytes))
      else $error("Byte index beyond the run.");

   // A run is released exactly when its last byte is loaded.
   assert property (@(posedge clock) disable iff (reset)
      run_pop |=> (out_valid_ff && out_ff.run_last && idx_ff == 2'd0))
      else $error("Run released without its last byte.");

   // Between runs the index rests at zero.
   assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> (idx_ff == 2'd0))
      else $error("Byte index left over with no run waiting.");

endmodule

// File: verif/tb_lsb_first_bit_packer.sv
`timescale 1ns / 100ps

module tb_lsb_first_bit_packer;

   // One queued code word, together with the idling that goes with it.
   typedef struct {
      lbp_pkg::req_type word;
      int unsigned      gap_pct;
      int unsigned      stall_pct;
      bit               wait_drain;
   } code_item_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   lbp_pkg::req_type req_word = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   lbp_pkg::rsp_type rsp_word;

   code_item_type    code_queue[$];
   lbp_pkg::rsp_type expected_bytes[$];
   lbp_pkg::rsp_type oldest_byte;
   logic [6:0]       held_bits = '0;
   logic [2:0]       held_count = '0;
   bit               req_taken = 1'b0;
   int unsigned      stall_pct = 0;
   int unsigned      mismatch_count = 0;

   lsb_first_bit_packer dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Append one code to the held bits and queue every byte that it completes.
   function automatic void pack_code(lbp_pkg::req_type w);
      int unsigned      code_len;
      int unsigned      total;
      int unsigned      nbytes;
      logic [63:0]      mask;
      logic [63:0]      acc;
      lbp_pkg::rsp_type b;
      code_len = (w.code_length > lbp_pkg::LenCap) ? lbp_pkg::LenCap : w.code_length;
      mask = (64'd1 << code_len) - 64'd1;
      acc = {57'd0, held_bits} | (({32'd0, w.code_value} & mask) << held_count);
      total = held_count + code_len;
      nbytes = total / 8;
      for (int k = 0; k < nbytes; k++) begin
         b.packed_byte = acc[k*8 +: 8];
         b.run_last = (k + 1 == nbytes);
         expected_bytes = {expected_bytes, b};
      end
      held_count = 3'(total % 8);
      held_bits = 7'(acc >> (nbytes * 8));
   endfunction

   function automatic void add_code(logic [31:0] v, logic [5:0] n, int unsigned gap,
                                    int unsigned stall, bit drain);
      code_item_type it;
      it.word.code_value = v;
      it.word.code_length = n;
      it.gap_pct = gap;
      it.stall_pct = stall;
      it.wait_drain = drain;
      code_queue = {code_queue, it};
   endfunction

   // Random length: mostly in range, with zero, full and saturated lengths mixed in.
   function automatic logic [5:0] random_length();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return 6'd0;
      else if (pick < 20) return 6'd32;
      else if (pick < 30) return 6'($urandom_range(63, 33));
      else return 6'($urandom_range(32, 1));
   endfunction

   // Monitor: predict on every accepted word and check every popped byte.
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_push && !req_full;
         if (req_taken) begin
            pack_code(req_word);
         end
         if (!rsp_empty && rsp_pop) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected byte: packed_byte %0h run_last %0b",
                      rsp_word.packed_byte, rsp_word.run_last);
               mismatch_count++;
            end else begin
               oldest_byte = expected_bytes.pop_front();
               if (rsp_word.packed_byte !== oldest_byte.packed_byte) begin
                  $error("packed_byte: expected %0h, got %0h",
                         oldest_byte.packed_byte, rsp_word.packed_byte);
                  mismatch_count++;
               end
               if (rsp_word.run_last !== oldest_byte.run_last) begin
                  $error("run_last: expected %0b, got %0b",
                         oldest_byte.run_last, rsp_word.run_last);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Driver: present queued words and stall the result side at random.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= stall_pct);
         if (!req_push || req_taken) begin
            if (code_queue.size() != 0
                && !(code_queue[0].wait_drain && expected_bytes.size() != 0)
                && $urandom_range(99) >= code_queue[0].gap_pct) begin
               req_word <= code_queue[0].word;
               req_push <= 1'b1;
               stall_pct = code_queue[0].stall_pct;
               void'(code_queue.pop_front());
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned gap;
      int unsigned stall;

      // Directed words: extremes, zero length, stray bits, saturation.
      add_code(32'hFFFF_FFFF, 6'd0, 0, 0, 0);
      add_code(32'hFFFF_FFFF, 6'd32, 0, 0, 0);
      add_code(32'h0000_0000, 6'd32, 0, 0, 0);
      add_code(32'h0000_00A5, 6'd8, 0, 0, 0);
      add_code(32'hFFFF_FFFD, 6'd3, 0, 0, 0);
      add_code(32'hFFFF_FFFF, 6'd0, 0, 0, 0);
      add_code(32'h0000_0001, 6'd1, 0, 0, 0);
      add_code(32'hFFFF_FF80, 6'd4, 0, 0, 0);
      add_code(32'h0000_003F, 6'd7, 0, 0, 0);
      add_code(32'h1234_5678, 6'd32, 0, 0, 0);
      add_code(32'hDEAD_BEEF, 6'd33, 0, 0, 0);
      add_code(32'hCAFE_F00D, 6'd63, 0, 0, 0);
      add_code(32'h8000_0000, 6'd32, 0, 0, 0);
      add_code(32'h5555_5555, 6'd17, 0, 0, 0);
      add_code(32'hAAAA_AAAA, 6'd31, 0, 0, 0);
      add_code(32'h0000_0000, 6'd1, 0, 0, 0);
      add_code(32'hFFFF_FFFF, 6'd2, 0, 0, 0);
      add_code(32'hFFFF_FFFF, 6'd5, 0, 0, 0);
      add_code(32'h7FFF_FFFF, 6'd48, 0, 0, 0);
      add_code(32'h0000_0100, 6'd9, 0, 0, 0);

      // Random words in four idling phases; the third starts after a full drain.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin gap = 0; stall = 0; end
            1: begin gap = 56; stall = 0; end
            2: begin gap = 0; stall = 56; end
            default: begin gap = 26; stall = 26; end
         endcase
         for (int i = 0; i < 38; i++) begin
            add_code($urandom, random_length(), gap, stall, (ph == 2 && i == 0));
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (code_queue.size() != 0 || req_push) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("PASS lsb_first_bit_packer");
      end else begin
         $display("FAIL lsb_first_bit_packer");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #400000;
      $display("FAIL lsb_first_bit_packer");
      $finish;
   end

endmodule
